// ----- hw/rtl/sitda_pkg.sv -----
package sitda_pkg;

    // Width of the binary input and the number of decimal digits it can need.
    localparam int C_BIN_W    = 32;
    localparam int C_DIGITS   = 10;
    localparam int C_BCD_W    = 4 * C_DIGITS;
    localparam int C_STEP_W   = $clog2(C_BIN_W);
    localparam int C_NDIG_W   = 4;

    localparam logic [7:0] C_ASCII_ZERO  = 8'h30;
    localparam logic [7:0] C_ASCII_NINE  = 8'h39;
    localparam logic [7:0] C_ASCII_MINUS = 8'h2D;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SIGN,
        ST_DIGIT
    } t_state;

endpackage

// ----- hw/rtl/sitda_dabble.sv -----
module sitda_dabble (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [sitda_pkg::C_BIN_W-1:0]       i_mag,
    output logic                                o_done,
    output logic [sitda_pkg::C_BCD_W-1:0]       o_bcd
);

    // Shift-and-add-3 converter: one binary bit enters the BCD register per cycle.
    logic [sitda_pkg::C_BIN_W-1:0]  r_bin;
    logic [sitda_pkg::C_BCD_W-1:0]  r_bcd;
    logic [sitda_pkg::C_STEP_W-1:0] r_cnt;
    logic                           r_run;
    logic                           r_done;

    logic [sitda_pkg::C_BIN_W-1:0]  n_bin;
    logic [sitda_pkg::C_BCD_W-1:0]  n_bcd;
    logic [sitda_pkg::C_STEP_W-1:0] n_cnt;
    logic                           n_run;
    logic                           n_done;
    logic [sitda_pkg::C_BCD_W-1:0]  w_adj;

    always_comb begin
        for (int i = 0; i < sitda_pkg::C_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_load) begin
            n_bin = i_mag;
            n_bcd = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_bcd = {w_adj[sitda_pkg::C_BCD_W-2:0], r_bin[sitda_pkg::C_BIN_W-1]};
            n_bin = {r_bin[sitda_pkg::C_BIN_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == sitda_pkg::C_STEP_W'(sitda_pkg::C_BIN_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_unit.sv -----
// Prints one signed 32-bit integer as decimal ASCII text. A request is taken
// when start is high while busy is low; busy then stays high until the last
// character of that number has been sent. Characters come out one per strobe
// on o_valid, most significant first: a '-' for negative values, then the
// digits without leading zeros, zero giving a single '0'. The most negative
// value prints as -2147483648. The final character has o_last set and carries
// the total character count, sign included; earlier characters carry a count
// of zero. The receiver cannot stall the block, so each character must be
// taken in the cycle its strobe is high. A request keeps the block busy while
// the shift-and-add-3 converter takes in the magnitude bit by bit, while the
// digits are handed over, while each digit position is either stripped as a
// leading zero or sent, while the count settles, and for the minus sign of a
// negative value. The busy time thus depends on the sign alone, whatever the
// number of digits.
module signed_int_to_decimal_ascii_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic [7:0]         o_character,
    output logic               o_last,
    output logic [3:0]         o_char_count
);

    localparam int C_TOP = sitda_pkg::C_BCD_W;

    sitda_pkg::t_state                r_state;
    sitda_pkg::t_state                n_state;
    logic                             r_neg;
    logic                             n_neg;
    logic [C_TOP-1:0]                 r_bcd;
    logic [C_TOP-1:0]                 n_bcd;
    logic [sitda_pkg::C_NDIG_W-1:0]   r_ndig;
    logic [sitda_pkg::C_NDIG_W-1:0]   n_ndig;
    logic [sitda_pkg::C_NDIG_W-1:0]   r_total;
    logic [sitda_pkg::C_NDIG_W-1:0]   n_total;
    logic                             r_valid;
    logic                             n_valid;
    logic [7:0]                       r_char;
    logic [7:0]                       n_char;
    logic                             r_last;
    logic                             n_last;
    logic [3:0]                       r_count;
    logic [3:0]                       n_count;

    logic                             w_load;
    logic [sitda_pkg::C_BIN_W-1:0]    w_mag;
    logic                             w_done;
    logic [C_TOP-1:0]                 w_bcd;
    logic [3:0]                       w_top;

    // Magnitude in unsigned arithmetic; the most negative value maps onto itself,
    // which read as unsigned is exactly 2147483648.
    assign w_mag = i_value[31] ? (32'd0 - $unsigned(i_value)) : $unsigned(i_value);
    assign w_top = r_bcd[C_TOP-1 -: 4];

    sitda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_bcd   = r_bcd;
        n_ndig  = r_ndig;
        n_total = r_total;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        n_count = '0;
        w_load  = 1'b0;
        unique case (r_state)
            sitda_pkg::ST_IDLE: begin
                if (start) begin
                    n_neg   = i_value[31];
                    w_load  = 1'b1;
                    n_state = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                if (w_done) begin
                    n_bcd   = w_bcd;
                    n_ndig  = sitda_pkg::C_NDIG_W'(sitda_pkg::C_DIGITS);
                    n_state = sitda_pkg::ST_TRIM;
                end
            end
            sitda_pkg::ST_TRIM: begin
                // Strip leading zero digits, always keeping at least one digit.
                if (w_top == 4'd0 && r_ndig > 4'd1) begin
                    n_bcd  = {r_bcd[C_TOP-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_total = r_ndig + {3'd0, r_neg};
                    n_state = r_neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
                end
            end
            sitda_pkg::ST_SIGN: begin
                n_valid = 1'b1;
                n_char  = sitda_pkg::C_ASCII_MINUS;
                n_state = sitda_pkg::ST_DIGIT;
            end
            sitda_pkg::ST_DIGIT: begin
                n_valid = 1'b1;
                n_char  = sitda_pkg::C_ASCII_ZERO + {4'd0, w_top};
                n_bcd   = {r_bcd[C_TOP-5:0], 4'd0};
                n_ndig  = r_ndig - 1'b1;
                if (r_ndig == 4'd1) begin
                    n_last  = 1'b1;
                    n_count = r_total;
                    n_state = sitda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_bcd   <= n_bcd;
        r_ndig  <= n_ndig;
        r_total <= n_total;
        r_char  <= n_char;
        r_last  <= n_last;
        r_count <= n_count;
    end

    assign busy         = (r_state != sitda_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_count;

`ifndef SYNTH
    // The final character of a number frees the block in the same cycle.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("block still busy on the final character");

    // Only the final character carries a count.
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_char_count == 4'd0))
        else $error("count set on a character that is not the last");

    // The count on the final character is within one to eleven.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_char_count >= 4'd1 && o_char_count <= 4'd11))
        else $error("character count out of range");

    // Every character sent is a minus sign or a decimal digit.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == sitda_pkg::C_ASCII_MINUS
                     || (o_character >= sitda_pkg::C_ASCII_ZERO
                         && o_character <= sitda_pkg::C_ASCII_NINE)))
        else $error("character outside the decimal set");

    // A minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == sitda_pkg::C_ASCII_MINUS) |-> !o_last)
        else $error("minus sign marked as last");
`endif

endmodule
